@@ hw/rtl/ptm_pkg.sv @@
package ptm_pkg;

    localparam int IDX_W = 9;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int DESC_W = 64;
    localparam int BASE_W = 28;

    localparam logic MODE_PAGE  = 1'b0;
    localparam logic MODE_BLOCK = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CONFLICT  = 2'd1;
    localparam logic [1:0] ST_NO_TABLES = 2'd2;

    localparam logic [1:0] DESC_KIND_BLOCK = 2'b01;
    localparam logic [1:0] DESC_KIND_TABLE = 2'b11;

    typedef struct packed {
        logic        mode;
        logic [38:0] virt_addr;
        logic [39:0] phys_addr;
        logic        user_access;
        logic        write_protect;
    } ptm_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DESC_W-1:0] descriptor;
        logic [6:0]        tables_used;
    } ptm_rsp_t;

    typedef struct packed {
        logic en;
        logic we;
    } ptm_mem_cmd_t;

    // Leaf descriptor: page or 1 GiB block, with AP[2:1] and the access flag.
    function automatic logic [DESC_W-1:0] make_leaf(input ptm_req_t req);
        logic [DESC_W-1:0] d;
        d = '0;
        d[10] = 1'b1;
        d[7]  = req.write_protect;
        d[6]  = req.user_access;
        if (req.mode == MODE_BLOCK)
        begin
            d[1:0]   = DESC_KIND_BLOCK;
            d[39:30] = req.phys_addr[39:30];
        end
        else
        begin
            d[1:0]   = DESC_KIND_TABLE;
            d[39:12] = req.phys_addr[39:12];
        end
        return d;
    endfunction

    // Table descriptor pointing at table number t above the configured base.
    function automatic logic [DESC_W-1:0] table_desc(input logic [BASE_W-1:0] base,
                                                     input logic [35:0] t);
        logic [35:0] page;
        page = 36'(base) + t;
        return {16'b0, page, 10'b0, DESC_KIND_TABLE};
    endfunction

endpackage

@@ hw/rtl/ptm_store.sv @@
module ptm_store #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptm_pkg::ptm_mem_cmd_t cmd,
    input  logic [AW-1:0]         addr,
    input  logic [63:0]           wdata,
    output logic [63:0]           rdata,
    output logic                  clearing
);
    import ptm_pkg::*;

    logic [64:0]   mem [DEPTH];
    logic [64:0]   rd_reg;
    logic          clr_active_reg;
    logic          clr_active_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    // After reset every entry is marked invalid, one entry per cycle.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.en && cmd.we)
        begin
            mem[addr] <= {1'b1, wdata};
        end
        if (cmd.en && !cmd.we)
        begin
            rd_reg <= mem[addr];
        end
    end

    assign rdata    = rd_reg[64] ? rd_reg[63:0] : 64'b0;
    assign clearing = clr_active_reg;

endmodule

@@ hw/rtl/ptm_walk.sv @@
module ptm_walk #(
    parameter int MAX_TABLES = 64,
    parameter int TIW        = 6,
    parameter int AW         = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  ptm_pkg::ptm_req_t     request,
    input  logic [27:0]           base,
    input  logic [63:0]           rdata,
    output ptm_pkg::ptm_mem_cmd_t mem_cmd,
    output logic [AW-1:0]         mem_addr,
    output logic [63:0]           mem_wdata,
    output logic                  active,
    output logic                  result_valid,
    output ptm_pkg::ptm_rsp_t     result
);
    import ptm_pkg::*;

    localparam int CW = $clog2(MAX_TABLES + 1);
    localparam logic [CW:0] MAX_C = (CW + 1)'(MAX_TABLES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_L1,
        S_L2,
        S_L3,
        S_W2,
        S_W3
    } state_t;

    state_t          state_reg, state_next;
    ptm_req_t        req_reg, req_next;
    logic [63:0]     desc_reg, desc_next;
    logic [TIW-1:0]  t2_reg, t2_next;
    logic [TIW-1:0]  t3_reg, t3_next;
    logic [CW-1:0]   nt_reg, nt_next;
    logic            rv_reg, rv_next;
    ptm_rsp_t        rsp_reg, rsp_next;

    logic [8:0]      i1, i2, i3;
    logic [35:0]     dec_page;
    logic [35:0]     dec_diff;
    logic            dec_ok;
    logic [TIW-1:0]  dec_t;
    logic            room1, room2;
    logic [CW+6:0]   nt_ext;

    assign i1 = req_reg.virt_addr[38:30];
    assign i2 = req_reg.virt_addr[29:21];
    assign i3 = req_reg.virt_addr[20:12];

    assign dec_page = rdata[47:12];
    assign dec_diff = dec_page - 36'(base);
    assign dec_ok   = (dec_page >= 36'(base)) && (dec_diff != 36'd0)
                      && (dec_diff < 36'(nt_reg));
    assign dec_t    = dec_diff[TIW-1:0];

    assign room2  = ({1'b0, nt_reg} + (CW + 1)'(2)) <= MAX_C;
    assign room1  = ({1'b0, nt_reg} + (CW + 1)'(1)) <= MAX_C;
    assign nt_ext = {7'b0, nt_next};

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        desc_next  = desc_reg;
        t2_next    = t2_reg;
        t3_next    = t3_reg;
        nt_next    = nt_reg;
        rv_next    = 1'b0;
        rsp_next   = rsp_reg;
        mem_cmd    = '0;
        mem_addr   = '0;
        mem_wdata  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next  = request;
                    desc_next = make_leaf(request);
                    mem_cmd.en = 1'b1;
                    mem_addr   = {{TIW{1'b0}}, request.virt_addr[38:30]};
                    if (request.mode == MODE_BLOCK)
                    begin
                        mem_cmd.we = 1'b1;
                        mem_wdata  = desc_next;
                        rv_next    = 1'b1;
                        rsp_next.status = ST_OK;
                    end
                    else
                    begin
                        state_next = S_L1;
                    end
                end
            end
            S_L1:
            begin
                if (rdata[1:0] == DESC_KIND_BLOCK)
                begin
                    rv_next = 1'b1;
                    rsp_next.status = ST_CONFLICT;
                end
                else if (!rdata[0])
                begin
                    if (!room2)
                    begin
                        rv_next = 1'b1;
                        rsp_next.status = ST_NO_TABLES;
                    end
                    else
                    begin
                        t2_next    = nt_reg[TIW-1:0];
                        t3_next    = t2_next + TIW'(1);
                        nt_next    = nt_reg + CW'(2);
                        mem_cmd.en = 1'b1;
                        mem_cmd.we = 1'b1;
                        mem_addr   = {{TIW{1'b0}}, i1};
                        mem_wdata  = table_desc(base, 36'(t2_next));
                        state_next = S_W2;
                    end
                end
                else if (!dec_ok)
                begin
                    rv_next = 1'b1;
                    rsp_next.status = ST_CONFLICT;
                end
                else
                begin
                    t2_next    = dec_t;
                    mem_cmd.en = 1'b1;
                    mem_addr   = {dec_t, i2};
                    state_next = S_L2;
                end
            end
            S_L2:
            begin
                if (rdata[1:0] == DESC_KIND_BLOCK)
                begin
                    rv_next = 1'b1;
                    rsp_next.status = ST_CONFLICT;
                end
                else if (!rdata[0])
                begin
                    if (!room1)
                    begin
                        rv_next = 1'b1;
                        rsp_next.status = ST_NO_TABLES;
                    end
                    else
                    begin
                        t3_next    = nt_reg[TIW-1:0];
                        nt_next    = nt_reg + CW'(1);
                        mem_cmd.en = 1'b1;
                        mem_cmd.we = 1'b1;
                        mem_addr   = {t2_reg, i2};
                        mem_wdata  = table_desc(base, 36'(t3_next));
                        state_next = S_W3;
                    end
                end
                else if (!dec_ok)
                begin
                    rv_next = 1'b1;
                    rsp_next.status = ST_CONFLICT;
                end
                else
                begin
                    t3_next    = dec_t;
                    mem_cmd.en = 1'b1;
                    mem_addr   = {dec_t, i3};
                    state_next = S_L3;
                end
            end
            S_L3:
            begin
                rv_next = 1'b1;
                rsp_next.status = ST_OK;
                if (rdata != desc_reg)
                begin
                    if (rdata[0])
                    begin
                        rsp_next.status = ST_CONFLICT;
                    end
                    else
                    begin
                        mem_cmd.en = 1'b1;
                        mem_cmd.we = 1'b1;
                        mem_addr   = {t3_reg, i3};
                        mem_wdata  = desc_reg;
                    end
                end
            end
            S_W2:
            begin
                mem_cmd.en = 1'b1;
                mem_cmd.we = 1'b1;
                mem_addr   = {t2_reg, i2};
                mem_wdata  = table_desc(base, 36'(t3_reg));
                state_next = S_W3;
            end
            S_W3:
            begin
                mem_cmd.en = 1'b1;
                mem_cmd.we = 1'b1;
                mem_addr   = {t3_reg, i3};
                mem_wdata  = desc_reg;
                rv_next    = 1'b1;
                rsp_next.status = ST_OK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rv_next)
        begin
            state_next = S_IDLE;
            rsp_next.descriptor  = desc_next;
            rsp_next.tables_used = nt_ext[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nt_reg    <= CW'(1);
            rv_reg    <= 1'b0;
            req_reg   <= '0;
            desc_reg  <= '0;
            t2_reg    <= '0;
            t3_reg    <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nt_reg    <= nt_next;
            rv_reg    <= rv_next;
            req_reg   <= req_next;
            desc_reg  <= desc_next;
            t2_reg    <= t2_next;
            t3_reg    <= t3_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign active       = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result       = rsp_reg;

endmodule

@@ hw/rtl/page_table_map_insert_engine.sv @@
// Channel    Signals                         Transfer when
// ---------  ------------------------------  ---------------------------
// request    start, busy, request            start high while busy low
// config     cfg_valid, cfg_ready, cfg_data  cfg_valid and cfg_ready high
// result     result_valid, result            result_valid high, one cycle
//
// A block map writes the root entry in the transfer cycle; its result shows on the next cycle.
// A page map reads one table level per cycle, checks the last entry read and writes the first
// descriptor if any, then writes each further descriptor, all through the single memory port.
// Its result shows on the cycle after. After reset, busy stays high while every memory entry
// is marked invalid. The receiver cannot stall results; each result is shown for one cycle.
module page_table_map_insert_engine #(
    parameter int MAX_TABLES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ptm_pkg::ptm_req_t request,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [27:0]       cfg_data,
    output logic              result_valid,
    output ptm_pkg::ptm_rsp_t result
);
    import ptm_pkg::*;

    localparam int TIW   = $clog2(MAX_TABLES);
    localparam int AW    = TIW + IDX_W;
    localparam int DEPTH = MAX_TABLES * ENTRIES_PER_TABLE;

    logic          cfg_wr;
    logic [27:0]   table_base_reg;
    ptm_mem_cmd_t  mem_cmd;
    logic [AW-1:0] mem_addr;
    logic [63:0]   mem_wdata;
    logic [63:0]   mem_rdata;
    logic          clearing;
    logic          walk_active;
    logic          accept;

    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;
    assign busy      = walk_active || clearing;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg <= '0;
        end
        else if (cfg_wr)
        begin
            table_base_reg <= cfg_data;
        end
    end

    ptm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mem_cmd),
        .addr     (mem_addr),
        .wdata    (mem_wdata),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

    ptm_walk #(
        .MAX_TABLES (MAX_TABLES),
        .TIW        (TIW),
        .AW         (AW)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .request      (request),
        .base         (table_base_reg),
        .rdata        (mem_rdata),
        .mem_cmd      (mem_cmd),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .active       (walk_active),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ tb/page_table_map_insert_engine_tb.sv @@
`timescale 1ns / 100ps

module page_table_map_insert_engine_tb;
    import ptm_pkg::*;

    localparam int TB_TABLES = 64;
    localparam int TB_DEPTH = TB_TABLES * ENTRIES_PER_TABLE;
    localparam logic [63:0] AF_BIT = 64'h400;
    localparam logic [63:0] AP1_BIT = 64'h40;
    localparam logic [63:0] AP2_BIT = 64'h80;
    localparam logic [63:0] BLOCK_PA_MASK = 64'h0000_FFFF_C000_0000;
    localparam logic [63:0] PAGE_PA_MASK = 64'h0000_FFFF_FFFF_F000;
    localparam logic [63:0] PTR_MASK = 64'h0000_FFFF_FFFF_F000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ptm_req_t request;
    logic cfg_valid;
    logic cfg_ready;
    logic [27:0] cfg_data;
    logic result_valid;
    ptm_rsp_t result;

    // Shadow copy of the translation tables and the allocator.
    logic [63:0] shadow_desc [TB_DEPTH];
    bit shadow_live [TB_DEPTH];
    int tables_next;
    logic [27:0] base_page;

    ptm_rsp_t pending_q [$];
    ptm_req_t page_hist [$];
    int burst_left;
    int errors;
    int n_page;
    int n_block;
    int n_checked;
    int n_ok;
    int n_conflict;
    int n_no_tables;
    int n_bases;

    page_table_map_insert_engine #(
        .MAX_TABLES(TB_TABLES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .result(result)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] entry_rd(input int unsigned t, input int unsigned i);
        int unsigned pos;
        pos = t * ENTRIES_PER_TABLE + i;
        if (pos >= TB_DEPTH || !shadow_live[pos])
            return 64'h0;
        return shadow_desc[pos];
    endfunction

    function automatic void entry_wr(input int unsigned t, input int unsigned i,
                                     input logic [63:0] v);
        int unsigned pos;
        pos = t * ENTRIES_PER_TABLE + i;
        if (pos < TB_DEPTH)
        begin
            shadow_desc[pos] = v;
            shadow_live[pos] = 1'b1;
        end
    endfunction

    function automatic int unsigned take_table();
        int unsigned t;
        t = tables_next;
        tables_next++;
        for (int k = 0; k < ENTRIES_PER_TABLE; k++)
        begin
            if (t * ENTRIES_PER_TABLE + k < TB_DEPTH)
                shadow_live[t * ENTRIES_PER_TABLE + k] = 1'b0;
        end
        return t;
    endfunction

    function automatic logic [63:0] ptr_desc(input int unsigned t);
        logic [63:0] page;
        page = 64'(base_page) + 64'(t);
        return ((page << 12) & PTR_MASK) | 64'(DESC_KIND_TABLE);
    endfunction

    function automatic bit ptr_decode(input logic [63:0] d, output int unsigned t);
        logic [63:0] idx;
        idx = ((d & PTR_MASK) >> 12) - 64'(base_page);
        t = 0;
        if (idx < 64'd1 || idx >= 64'(tables_next))
            return 1'b0;
        t = int'(idx[31:0]);
        return 1'b1;
    endfunction

    function automatic ptm_rsp_t predict_map(input ptm_req_t r);
        ptm_rsp_t rsp;
        logic [63:0] leaf;
        logic [63:0] pa;
        logic [63:0] e1;
        logic [63:0] e2;
        logic [63:0] e3;
        logic [1:0] st;
        int unsigned i1;
        int unsigned i2;
        int unsigned i3;
        int unsigned t2;
        int unsigned t3;
        pa = 64'(r.phys_addr);
        i1 = 32'(r.virt_addr[38:30]);
        i2 = 32'(r.virt_addr[29:21]);
        i3 = 32'(r.virt_addr[20:12]);
        leaf = AF_BIT;
        if (r.user_access)
            leaf |= AP1_BIT;
        if (r.write_protect)
            leaf |= AP2_BIT;
        st = ST_OK;
        if (r.mode == MODE_BLOCK)
        begin
            leaf |= 64'(DESC_KIND_BLOCK) | (pa & BLOCK_PA_MASK);
            entry_wr(0, i1, leaf);
        end
        else
        begin
            leaf |= 64'(DESC_KIND_TABLE) | (pa & PAGE_PA_MASK);
            e1 = entry_rd(0, i1);
            if (e1[1:0] == DESC_KIND_BLOCK)
                st = ST_CONFLICT;
            else if (!e1[0])
            begin
                if (TB_TABLES - tables_next < 2)
                    st = ST_NO_TABLES;
                else
                begin
                    t2 = take_table();
                    t3 = take_table();
                    entry_wr(0, i1, ptr_desc(t2));
                    entry_wr(t2, i2, ptr_desc(t3));
                    entry_wr(t3, i3, leaf);
                end
            end
            else if (!ptr_decode(e1, t2))
                st = ST_CONFLICT;
            else
            begin
                e2 = entry_rd(t2, i2);
                if (e2[1:0] == DESC_KIND_BLOCK)
                    st = ST_CONFLICT;
                else if (!e2[0])
                begin
                    if (TB_TABLES - tables_next < 1)
                        st = ST_NO_TABLES;
                    else
                    begin
                        t3 = take_table();
                        entry_wr(t2, i2, ptr_desc(t3));
                        entry_wr(t3, i3, leaf);
                    end
                end
                else if (!ptr_decode(e2, t3))
                    st = ST_CONFLICT;
                else
                begin
                    e3 = entry_rd(t3, i3);
                    if (e3 != leaf)
                    begin
                        if (e3[0])
                            st = ST_CONFLICT;
                        else
                            entry_wr(t3, i3, leaf);
                    end
                end
            end
        end
        rsp.status = st;
        rsp.descriptor = leaf;
        rsp.tables_used = 7'(tables_next);
        return rsp;
    endfunction

    function automatic ptm_req_t make_req(input logic mode, input logic [38:0] va,
                                          input logic [39:0] pa, input logic ua,
                                          input logic wp);
        ptm_req_t r;
        r.mode = mode;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.user_access = ua;
        r.write_protect = wp;
        return r;
    endfunction

    // Most page maps stay inside a few root and level-2 slots so that existing tables are
    // reused; blocks go to the upper half of the root table, away from those slots.
    function automatic ptm_req_t rand_map();
        ptm_req_t r;
        ptm_req_t prior;
        int roll;
        roll = $urandom_range(0, 99);
        r.mode = MODE_PAGE;
        r.virt_addr = 39'({$urandom, $urandom});
        r.phys_addr = 40'({$urandom, $urandom});
        r.user_access = 1'($urandom);
        r.write_protect = 1'($urandom);
        if (roll < 10)
        begin
            r.mode = MODE_BLOCK;
            if ($urandom_range(0, 3) != 0)
                r.virt_addr[38:30] = 9'(256 + $urandom_range(0, 3));
            else
                r.virt_addr[38] = 1'b1;
        end
        else if (roll < 30 && page_hist.size() != 0)
        begin
            prior = page_hist[$urandom_range(0, page_hist.size() - 1)];
            if (roll < 22)
                r = prior;
            else
                r.virt_addr = prior.virt_addr;
        end
        else if (roll < 33)
            r.virt_addr[38:30] = 9'(256 + $urandom_range(0, 3));
        else if (roll >= 34)
        begin
            r.virt_addr[38:30] = 9'($urandom_range(0, 3));
            r.virt_addr[29:21] = 9'($urandom_range(0, 3));
        end
        if (r.mode == MODE_PAGE)
        begin
            page_hist.push_back(r);
            if (page_hist.size() > 64)
                void'(page_hist.pop_front());
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_map(input ptm_req_t r);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        request <= r;
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_q.push_back(predict_map(r));
        if (r.mode == MODE_BLOCK)
            n_block++;
        else
            n_page++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [27:0] v);
        drain_results();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        base_page = v;
        n_bases++;
    endtask

    task automatic test_directed_maps();
        send_map(make_req(MODE_PAGE, 39'h0, 40'h0, 1'b0, 1'b0));
        send_map(make_req(MODE_PAGE, 39'h0, 40'h0, 1'b0, 1'b0));
        send_map(make_req(MODE_PAGE, 39'h0, 40'hFF_FFFF_F000, 1'b1, 1'b1));
        send_map(make_req(MODE_PAGE, 39'h1000, '1, 1'b1, 1'b0));
        send_map(make_req(MODE_PAGE, '1, '1, 1'b1, 1'b1));
        send_map(make_req(MODE_PAGE, {9'd511, 9'd0, 21'h0}, 40'h12_3456_7FFF, 1'b0, 1'b1));
        send_map(make_req(MODE_BLOCK, {9'd300, 30'h2345_6789}, '1, 1'b1, 1'b1));
        send_map(make_req(MODE_BLOCK, {9'd300, 30'h0}, 40'h0, 1'b0, 1'b0));
        send_map(make_req(MODE_PAGE, {9'd300, 30'h1000}, 40'h5000, 1'b0, 1'b0));
        send_map(make_req(MODE_BLOCK, {9'd511, 30'h3FFF_FFFF}, 40'hAA_C000_0000, 1'b0, 1'b1));
        send_map(make_req(MODE_PAGE, '1, '1, 1'b1, 1'b1));
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
            send_map(rand_map());
    endtask

    // Table pointers written under one base decode to other tables, or out of range,
    // once the base moves.
    task automatic test_base_register();
        write_base(28'hFFF_FFFF);
        send_map(make_req(MODE_PAGE, 39'h0, 40'h0, 1'b0, 1'b0));
        send_map(make_req(MODE_PAGE, {9'd10, 30'h0}, 40'h77_0000_1000, 1'b1, 1'b0));
        send_map(make_req(MODE_PAGE, {9'd10, 30'h0}, 40'h77_0000_1000, 1'b1, 1'b0));
        send_map(make_req(MODE_PAGE, {9'd10, 9'd0, 9'd5, 12'h0}, 40'h1, 1'b0, 1'b1));
        test_random_traffic(60);
        write_base(28'h1);
        test_random_traffic(80);
        write_base(28'($urandom_range(2, 28'hFFF_FFFE)));
        test_random_traffic(40);
        write_base(28'h0);
    endtask

    task automatic test_table_exhaustion();
        for (int k = 0; k < TB_TABLES && tables_next < TB_TABLES - 1; k++)
        begin
            if (TB_TABLES - tables_next >= 3)
                send_map(make_req(MODE_PAGE, {9'(100 + k), 30'h0}, 40'h1000, 1'b0, 1'b0));
            else
                send_map(make_req(MODE_PAGE, {9'd0, 9'(100 + k), 21'h0}, 40'h2000, 1'b0, 1'b0));
        end
        send_map(make_req(MODE_PAGE, {9'd200, 30'h0}, 40'h3000, 1'b1, 1'b0));
        send_map(make_req(MODE_PAGE, {9'd0, 9'd200, 21'h0}, 40'h4000, 1'b0, 1'b1));
        send_map(make_req(MODE_PAGE, {9'd0, 9'd201, 21'h0}, 40'h5000, 1'b1, 1'b1));
        send_map(make_req(MODE_PAGE, {9'd200, 30'h0}, 40'h3000, 1'b1, 1'b0));
    endtask

    always @(posedge clk)
    begin
        ptm_rsp_t want;
        if (rst_n && result_valid)
        begin
            if (pending_q.size() == 0)
            begin
                report("result with nothing pending", 64'(result.status), 64'h0);
            end
            else
            begin
                want = pending_q.pop_front();
                n_checked++;
                if (want.status == ST_OK)
                    n_ok++;
                else if (want.status == ST_CONFLICT)
                    n_conflict++;
                else
                    n_no_tables++;
                if (result.status !== want.status)
                    report("status", 64'(result.status), 64'(want.status));
                if (result.descriptor !== want.descriptor)
                    report("descriptor", result.descriptor, want.descriptor);
                if (result.tables_used !== want.tables_used)
                    report("tables_used", 64'(result.tables_used), 64'(want.tables_used));
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("Timeout with %0d results outstanding.", pending_q.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        for (int i = 0; i < TB_DEPTH; i++)
            shadow_live[i] = 1'b0;
        tables_next = 1;
        base_page = '0;
        burst_left = 0;
        errors = 0;
        n_page = 0;
        n_block = 0;
        n_checked = 0;
        n_ok = 0;
        n_conflict = 0;
        n_no_tables = 0;
        n_bases = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_base(28'h0);
        test_directed_maps();
        test_random_traffic(700);
        test_base_register();
        test_table_exhaustion();
        test_random_traffic(250);

        drain_results();
        repeat (20) @(posedge clk);
        $display("Checked %0d results from %0d page and %0d block maps over %0d base settings.",
                 n_checked, n_page, n_block, n_bases);
        $display("Outcomes: %0d ok, %0d slot conflicts, %0d out of tables; %0d tables in use.",
                 n_ok, n_conflict, n_no_tables, tables_next);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ptm_pkg.sv
hw/rtl/ptm_store.sv
hw/rtl/ptm_walk.sv
hw/rtl/page_table_map_insert_engine.sv
tb/page_table_map_insert_engine_tb.sv
